### rtl/core/chase_flee_steering_step_macros.svh
// Assertion macros shared by the steering block.
// No dependencies; included by the modules that carry assertions.
`ifndef CHASE_FLEE_STEERING_STEP_MACROS_SVH
`define CHASE_FLEE_STEERING_STEP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define CFS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define CFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFS_ASSERT(lbl, clk, rst, prop, msg)
`define CFS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/cfs_pkg.sv
// Types, constants and helper functions for the chase/flee steering block.
// No dependencies; used by the serial unit, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package cfs_pkg;

  localparam int FRAC_BITS_DEF  = 8;
  localparam int STOP_RADIUS_SQ = 1600;
  localparam int GROUND_DIV     = 10;

  localparam int MUL_STEPS  = 32;
  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 32;

  localparam logic [23:0]        FLEE_RADIUS_SQ_RST = 24'd14400;
  localparam logic signed [23:0] GROUND_Y_RST       = 24'sd117760;
  localparam logic signed [23:0] LEFT_STOP_X_RST    = 24'sd26112;
  localparam logic signed [23:0] RIGHT_STOP_X_RST   = 24'sd235776;
  localparam logic signed [23:0] STOP_Y_RST         = 24'sd19712;
  localparam logic [15:0]        MAX_SPEED_RST      = 16'd768;
  localparam logic [15:0]        MAX_FORCE_RST      = 16'd13;
  localparam logic [15:0]        CHASE_WEIGHT_RST   = 16'd256;

  localparam logic [2:0] REG_FLEE_RADIUS_SQ = 3'd0;
  localparam logic [2:0] REG_GROUND_Y       = 3'd1;
  localparam logic [2:0] REG_LEFT_STOP_X    = 3'd2;
  localparam logic [2:0] REG_RIGHT_STOP_X   = 3'd3;
  localparam logic [2:0] REG_STOP_Y         = 3'd4;
  localparam logic [2:0] REG_MAX_SPEED      = 3'd5;
  localparam logic [2:0] REG_MAX_FORCE      = 3'd6;
  localparam logic [2:0] REG_CHASE_WEIGHT   = 3'd7;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X_GO,
    ST_SQ_X,
    ST_SQ_Y,
    ST_FLEE_TEST,
    ST_STOP_TEST,
    ST_SEEK,
    ST_NORM,
    ST_NORM_SQRT,
    ST_MD_X_GO,
    ST_MD_X_MUL,
    ST_MD_X_DIV,
    ST_MD_Y_MUL,
    ST_MD_Y_DIV,
    ST_SUB,
    ST_LIM,
    ST_LIM_K2,
    ST_LIM_CMP,
    ST_LIM_SQRT,
    ST_WEIGHT,
    ST_NEG,
    ST_GROUND,
    ST_GROUND_DIV,
    ST_VEL,
    ST_UPD,
    ST_POS,
    ST_DONE
  } state_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      sat24 = 24'sd8388607;
    end else if (v < -32'sd8388608) begin
      sat24 = -24'sd8388608;
    end else begin
      sat24 = v[23:0];
    end
  endfunction

endpackage
`default_nettype wire

### rtl/core/cfs_channels.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
`default_nettype none
interface cfs_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [23:0] target_x;
  logic signed [23:0] target_y;
  logic signed [23:0] place_x;
  logic signed [23:0] place_y;

  modport source (output valid, mode, target_x, target_y, place_x, place_y, input ready);
  modport sink   (input valid, mode, target_x, target_y, place_x, place_y, output ready);
endinterface

interface cfs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_pos_x;
  logic signed [23:0] out_pos_y;
  logic signed [23:0] out_vel_x;
  logic signed [23:0] out_vel_y;
  logic               out_fleeing;

  modport source (output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_fleeing,
                  input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_fleeing,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/cfs_serial_unit.sv
// Shared bit-serial arithmetic unit: multiply, divide, integer square root.
// Depends on cfs_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "chase_flee_steering_step_macros.svh"
module cfs_serial_unit (
  input  logic              clk,
  input  logic              rst,
  input  cfs_pkg::unit_req_t req,
  input  logic [63:0]       a,
  input  logic [31:0]       b,
  output logic              busy,
  output logic [63:0]       res
);
  import cfs_pkg::*;

  unit_op_t    op;
  logic [5:0]  cnt;
  logic [5:0]  last;
  logic [63:0] acc;
  logic [63:0] sh;
  logic [31:0] bq;
  logic [33:0] rem;
  logic [31:0] root;

  logic [32:0] div_cur;
  logic        div_ge;
  logic [35:0] sq_cur;
  logic [35:0] sq_trial;
  logic        sq_ge;

  always_comb begin
    unique case (op)
      OP_MUL:  last = 6'(MUL_STEPS - 1);
      OP_DIV:  last = 6'(DIV_STEPS - 1);
      OP_SQRT: last = 6'(SQRT_STEPS - 1);
      default: last = 6'(MUL_STEPS - 1);
    endcase
  end

  assign div_cur  = {rem[31:0], sh[47]};
  assign div_ge   = div_cur >= {1'b0, bq};
  assign sq_cur   = {rem, sh[63:62]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = sq_cur >= sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      op   <= OP_MUL;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      op   <= req.op;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == last) begin
        busy <= 1'b0;
      end
    end
  end

  // one bit of product, quotient or root per cycle while busy
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= '0;
      rem  <= '0;
      root <= '0;
      bq   <= b;
      sh   <= (req.op == OP_MUL) ? {32'd0, a[31:0]} : a;
    end else if (busy) begin
      case (op)
        OP_MUL: begin
          if (bq[0]) begin
            acc <= acc + sh;
          end
          sh <= {sh[62:0], 1'b0};
          bq <= {1'b0, bq[31:1]};
        end
        OP_DIV: begin
          rem[32:0] <= div_ge ? (div_cur - {1'b0, bq}) : div_cur;
          sh        <= {16'd0, sh[46:0], div_ge};
        end
        default: begin
          rem  <= sq_ge ? 34'(sq_cur - sq_trial) : sq_cur[33:0];
          root <= {root[30:0], sq_ge};
          sh   <= {sh[61:0], 2'b00};
        end
      endcase
    end
  end

  always_comb begin
    case (op)
      OP_MUL:  res = acc;
      OP_DIV:  res = {16'd0, sh[47:0]};
      default: res = {32'd0, root};
    endcase
  end

  `CFS_ASSERT(a_start_loads, clk, rst, req.start |=> (busy && cnt == 6'd0), "start did not load")
  `CFS_ASSERT_ALWAYS(a_last_ends, clk, (busy && cnt == last && !req.start) |=> !busy, "overrun")
  `CFS_ASSERT(a_fell_at_last, clk, rst, $fell(busy) |-> $past(cnt == last), "early finish")

endmodule
`default_nettype wire

### rtl/core/chase_flee_steering_step.sv
// Chase/flee steering agent: one agent step per input beat, one result beat per step.
// A place beat goes straight to the result register; a tick beat runs the sequencer
//   through the shared serial unit (bit-serial multiply, divide and square root).
// Throughput: one beat in flight; the next beat is taken once the step finishes,
//   while the previous result may still wait in the output register.
// Reset (rst, synchronous): agent at rest at the origin in chase state, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "chase_flee_steering_step_macros.svh"
module chase_flee_steering_step #(
  parameter int FRAC_BITS = cfs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cfs_req_if.sink     req,
  cfs_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfs_pkg::*;

  // configuration registers
  logic [23:0]        flee_radius_sq;
  logic signed [23:0] ground_y;
  logic signed [23:0] left_stop_x;
  logic signed [23:0] right_stop_x;
  logic signed [23:0] stop_y;
  logic [15:0]        max_speed;
  logic [15:0]        max_force;
  logic [15:0]        chase_weight;

  // agent state
  logic signed [23:0] px, py, vx, vy;
  logic               fleeing;

  // working registers of one step
  logic signed [23:0] tx, ty, gx, gy;
  logic signed [31:0] wx, wy;
  logic [63:0]        ss;
  logic [15:0]        k;
  logic [31:0]        dv;
  logic               flee_branch;
  logic               is_place;
  state_t             state, state_next, ret, ret_lim;

  // result register
  logic               rsp_valid;
  logic signed [23:0] o_px, o_py, o_vx, o_vy;
  logic               o_fleeing;

  // serial unit
  unit_req_t          ureq;
  logic [63:0]        ua;
  logic [31:0]        ub;
  logic               ubusy;
  logic [63:0]        ures;

  // decisions
  logic [63:0]        flee_lim;
  logic [63:0]        stop_lim;
  logic               flee_hit;
  logic               stop_hit;
  logic               below_ground;
  logic [31:0]        gdepth;
  logic signed [23:0] stop_x_sel;
  logic signed [31:0] qx_signed, qy_signed;
  logic               cfg_wr;

  assign flee_lim     = 64'(flee_radius_sq) << (2 * FRAC_BITS);
  assign stop_lim     = 64'(STOP_RADIUS_SQ) << (2 * FRAC_BITS);
  assign flee_hit     = ss < flee_lim;
  assign stop_hit     = ss < stop_lim;
  assign below_ground = py > ground_y;
  assign gdepth       = 32'(32'(py) - 32'(ground_y));
  assign stop_x_sel   = vx[23] ? left_stop_x : right_stop_x;
  // apply the sign of the component to the unsigned quotient
  assign qx_signed    = wx[31] ? -$signed(ures[31:0]) : $signed(ures[31:0]);
  assign qy_signed    = wy[31] ? -$signed(ures[31:0]) : $signed(ures[31:0]);

  // ---------------------------------------------------------------------------
  // Configuration port: writes land on the access cycle, reads are combinational.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flee_radius_sq <= FLEE_RADIUS_SQ_RST;
      ground_y       <= GROUND_Y_RST;
      left_stop_x    <= LEFT_STOP_X_RST;
      right_stop_x   <= RIGHT_STOP_X_RST;
      stop_y         <= STOP_Y_RST;
      max_speed      <= MAX_SPEED_RST;
      max_force      <= MAX_FORCE_RST;
      chase_weight   <= CHASE_WEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_FLEE_RADIUS_SQ: flee_radius_sq <= pwdata[23:0];
        REG_GROUND_Y:       ground_y       <= pwdata[23:0];
        REG_LEFT_STOP_X:    left_stop_x    <= pwdata[23:0];
        REG_RIGHT_STOP_X:   right_stop_x   <= pwdata[23:0];
        REG_STOP_Y:         stop_y         <= pwdata[23:0];
        REG_MAX_SPEED:      max_speed      <= pwdata[15:0];
        REG_MAX_FORCE:      max_force      <= pwdata[15:0];
        REG_CHASE_WEIGHT:   chase_weight   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FLEE_RADIUS_SQ: prdata = {8'd0, flee_radius_sq};
      REG_GROUND_Y:       prdata = 32'(ground_y);
      REG_LEFT_STOP_X:    prdata = 32'(left_stop_x);
      REG_RIGHT_STOP_X:   prdata = 32'(right_stop_x);
      REG_STOP_Y:         prdata = 32'(stop_y);
      REG_MAX_SPEED:      prdata = {16'd0, max_speed};
      REG_MAX_FORCE:      prdata = {16'd0, max_force};
      REG_CHASE_WEIGHT:   prdata = {16'd0, chase_weight};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer. The squared length (SQ_*), the scale by k over dv (MD_*) and the
  // limit (LIM_*) are subroutines; ret and ret_lim hold where each one returns.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (req.valid) state_next = req.mode ? ST_DONE : ST_SQ_X_GO;
      ST_SQ_X_GO:    state_next = ST_SQ_X;
      ST_SQ_X:       if (!ubusy) state_next = ST_SQ_Y;
      ST_SQ_Y:       if (!ubusy) state_next = ret;
      ST_FLEE_TEST:  state_next = (!flee_hit && fleeing) ? ST_SQ_X_GO : ST_SEEK;
      ST_STOP_TEST:  state_next = ST_SEEK;
      ST_SEEK:       state_next = ST_SQ_X_GO;
      ST_NORM:       state_next = (ss == 64'd0) ? ST_SUB : ST_NORM_SQRT;
      ST_NORM_SQRT:  if (!ubusy) state_next = ST_MD_X_GO;
      ST_MD_X_GO:    state_next = ST_MD_X_MUL;
      ST_MD_X_MUL:   if (!ubusy) state_next = ST_MD_X_DIV;
      ST_MD_X_DIV:   if (!ubusy) state_next = ST_MD_Y_MUL;
      ST_MD_Y_MUL:   if (!ubusy) state_next = ST_MD_Y_DIV;
      ST_MD_Y_DIV:   if (!ubusy) state_next = ret;
      ST_SUB:        state_next = ST_LIM;
      ST_LIM:        state_next = ST_SQ_X_GO;
      ST_LIM_K2:     state_next = ST_LIM_CMP;
      ST_LIM_CMP:    if (!ubusy) state_next = (ss > ures) ? ST_LIM_SQRT : ret_lim;
      ST_LIM_SQRT:   if (!ubusy) state_next = ST_MD_X_GO;
      ST_WEIGHT:     state_next = ST_MD_X_GO;
      ST_NEG:        state_next = ST_GROUND;
      ST_GROUND:     state_next = below_ground ? ST_GROUND_DIV : ST_VEL;
      ST_GROUND_DIV: if (!ubusy) state_next = ST_VEL;
      ST_VEL:        state_next = ST_LIM;
      ST_UPD:        state_next = ST_POS;
      ST_POS:        state_next = ST_DONE;
      ST_DONE:       if (!rsp_valid || rsp.ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // unit requests and handshake outputs
  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = OP_MUL;
    ua         = '0;
    ub         = '0;
    unique case (state)
      ST_SQ_X_GO: begin
        ureq.start = 1'b1;
        ua         = {32'd0, mag32(wx)};
        ub         = mag32(wx);
      end
      ST_SQ_X: begin
        ureq.start = !ubusy;
        ua         = {32'd0, mag32(wy)};
        ub         = mag32(wy);
      end
      ST_NORM: begin
        ureq.start = (ss != 64'd0);
        ureq.op    = OP_SQRT;
        ua         = ss;
      end
      ST_MD_X_GO: begin
        ureq.start = 1'b1;
        ua         = {32'd0, mag32(wx)};
        ub         = {16'd0, k};
      end
      ST_MD_X_MUL, ST_MD_Y_MUL: begin
        ureq.start = !ubusy;
        ureq.op    = OP_DIV;
        ua         = ures;
        ub         = dv;
      end
      ST_MD_X_DIV: begin
        ureq.start = !ubusy;
        ua         = {32'd0, mag32(wy)};
        ub         = {16'd0, k};
      end
      ST_LIM_K2: begin
        ureq.start = 1'b1;
        ua         = {48'd0, k};
        ub         = {16'd0, k};
      end
      ST_LIM_CMP: begin
        ureq.start = !ubusy && (ss > ures);
        ureq.op    = OP_SQRT;
        ua         = ss;
      end
      ST_GROUND: begin
        ureq.start = below_ground;
        ureq.op    = OP_DIV;
        ua         = {32'd0, gdepth};
        ub         = 32'(GROUND_DIV);
      end
      default: ;
    endcase
  end

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.out_pos_x   = o_px;
  assign rsp.out_pos_y   = o_py;
  assign rsp.out_vel_x   = o_vx;
  assign rsp.out_vel_y   = o_vy;
  assign rsp.out_fleeing = o_fleeing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // agent state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      px        <= '0;
      py        <= '0;
      vx        <= '0;
      vy        <= '0;
      fleeing   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if (state == ST_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid && req.mode) begin
            px <= req.place_x;
            py <= req.place_y;
            vx <= '0;
            vy <= '0;
          end
        end
        ST_FLEE_TEST: if (flee_hit) fleeing <= 1'b1;
        ST_STOP_TEST: if (stop_hit) fleeing <= 1'b0;
        ST_GROUND:    if (below_ground) fleeing <= 1'b1;
        ST_UPD: begin
          vx <= sat24(wx);
          vy <= sat24(wy);
        end
        ST_POS: begin
          px <= sat24(32'(px) + 32'(vx));
          py <= sat24(32'(py) + 32'(vy));
        end
        default: ;
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          is_place <= req.mode;
          tx       <= req.target_x;
          ty       <= req.target_y;
          wx       <= 32'(px) - 32'(req.target_x);
          wy       <= 32'(py) - 32'(req.target_y);
          ret      <= ST_FLEE_TEST;
        end
      end
      ST_SQ_X:  if (!ubusy) ss <= ures;
      ST_SQ_Y:  if (!ubusy) ss <= ss + ures;
      ST_FLEE_TEST: begin
        flee_branch <= flee_hit;
        if (!flee_hit && fleeing) begin
          // head for the stop ahead of the velocity, check the rest distance first
          gx  <= stop_x_sel;
          gy  <= stop_y;
          wx  <= 32'(px) - 32'(stop_x_sel);
          wy  <= 32'(py) - 32'(stop_y);
          ret <= ST_STOP_TEST;
        end else begin
          gx <= tx;
          gy <= ty;
        end
      end
      ST_SEEK: begin
        wx  <= 32'(gx) - 32'(px);
        wy  <= 32'(gy) - 32'(py);
        ret <= ST_NORM;
      end
      ST_NORM: begin
        if (ss == 64'd0) begin
          wx <= '0;
          wy <= '0;
        end
      end
      ST_NORM_SQRT: begin
        if (!ubusy) begin
          dv  <= ures[31:0];
          k   <= max_speed;
          ret <= ST_SUB;
        end
      end
      ST_MD_X_DIV: if (!ubusy) wx <= qx_signed;
      ST_MD_Y_DIV: if (!ubusy) wy <= qy_signed;
      ST_SUB: begin
        wx      <= wx - 32'(vx);
        wy      <= wy - 32'(vy);
        k       <= max_force;
        ret_lim <= ST_WEIGHT;
      end
      ST_LIM:   ret <= ST_LIM_K2;
      ST_LIM_SQRT: begin
        if (!ubusy) begin
          dv  <= ures[31:0];
          ret <= ret_lim;
        end
      end
      ST_WEIGHT: begin
        k   <= chase_weight;
        dv  <= 32'd1 << FRAC_BITS;
        ret <= ST_NEG;
      end
      ST_NEG: begin
        if (flee_branch) begin
          wx <= -wx;
          wy <= -wy;
        end
      end
      ST_GROUND_DIV: if (!ubusy) wy <= wy - $signed(ures[31:0]);
      ST_VEL: begin
        wx      <= wx + 32'(vx);
        wy      <= wy + 32'(vy);
        k       <= max_speed;
        ret_lim <= ST_UPD;
      end
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          o_px      <= px;
          o_py      <= py;
          o_vx      <= vx;
          o_vy      <= vy;
          o_fleeing <= fleeing;
        end
      end
      default: ;
    endcase
  end

  cfs_serial_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .a    (ua),
    .b    (ub),
    .busy (ubusy),
    .res  (ures)
  );

  `CFS_ASSERT(a_no_start_busy, clk, rst, ureq.start |-> !ubusy, "unit started while busy")
  `CFS_ASSERT(a_result_from_done, clk, rst, $rose(rsp_valid) |-> $past(state == ST_DONE), "stray result")
  `CFS_ASSERT(a_place_rest, clk, rst, (state == ST_DONE && is_place) |-> (vx == 24'sd0 && vy == 24'sd0), "place left velocity")

endmodule
`default_nettype wire

### sim/tb_chase_flee_steering_step.sv
// Self-checking testbench for the chase/flee steering block: drives agent steps and
// register writes, predicts each step result and compares every result beat.
// Depends on cfs_pkg, the cfs_req_if/cfs_rsp_if channels and chase_flee_steering_step.
`timescale 1ns / 1ps
module tb_chase_flee_steering_step;
  import cfs_pkg::*;

  localparam bit MODE_TICK  = 1'b0;
  localparam bit MODE_PLACE = 1'b1;
  localparam longint SAT_HI = 64'sd8388607;
  localparam longint SAT_LO = -64'sd8388608;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int STALL_CYCLES = 3000;

  typedef struct {
    bit                 mode;
    logic signed [23:0] tx, ty, px, py;
  } step_t;

  typedef struct {
    logic signed [23:0] pos_x, pos_y, vel_x, vel_y;
    logic               flee;
  } agent_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cfs_req_if req_ch ();
  cfs_rsp_if rsp_ch ();

  chase_flee_steering_step dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: registers and agent state, advanced on every accepted step.
  logic [23:0]        sh_radius_sq;
  logic signed [23:0] sh_ground_y, sh_left_x, sh_right_x, sh_stop_y;
  logic [15:0]        sh_max_speed, sh_max_force, sh_weight;
  longint             ag_px, ag_py, ag_vx, ag_vy;
  bit                 ag_flee;

  step_t  step_q[$];
  agent_t agent_q[$];
  int     errors = 0;
  int     steps_sent = 0;
  int     beats_seen = 0;
  int     places_sent = 0;
  int     flee_beats = 0;
  bit     step_held = 1'b0;
  bit     no_idle = 1'b0;
  int     stall_ask = 0;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // a*m/d truncated toward zero
  function automatic longint scale(longint a, longint unsigned m, longint unsigned d);
    longint unsigned q;
    q = mag(a) * m / d;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned len_sq(longint x, longint y);
    return mag(x) * mag(x) + mag(y) * mag(y);
  endfunction

  function automatic longint clamp24(longint v);
    return v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
  endfunction

  task automatic clip(inout longint x, inout longint y, input longint unsigned lim);
    longint unsigned ss, s;
    ss = len_sq(x, y);
    if (ss > lim * lim) begin
      s = floor_root(ss);
      x = scale(x, lim, s);
      y = scale(y, lim, s);
    end
  endtask

  // Seek steering force toward a goal from the current agent state.
  task automatic steer_toward(input longint gx, input longint gy,
                              output longint fx, output longint fy);
    longint dx, dy, wx, wy, sx, sy;
    longint unsigned l2, m;
    dx = gx - ag_px;
    dy = gy - ag_py;
    wx = 0;
    wy = 0;
    l2 = len_sq(dx, dy);
    if (l2 != 0) begin
      m = floor_root(l2);
      wx = scale(dx, sh_max_speed, m);
      wy = scale(dy, sh_max_speed, m);
    end
    sx = wx - ag_vx;
    sy = wy - ag_vy;
    clip(sx, sy, sh_max_force);
    fx = scale(sx, sh_weight, 64'd1 << FRAC_BITS_DEF);
    fy = scale(sy, sh_weight, 64'd1 << FRAC_BITS_DEF);
  endtask

  task automatic advance_agent(input step_t s);
    longint tx, ty, ax, ay, gx, vx, vy;
    longint unsigned d2, ds;
    agent_t a;
    if (s.mode == MODE_PLACE) begin
      ag_px = s.px;
      ag_py = s.py;
      ag_vx = 0;
      ag_vy = 0;
    end else begin
      tx = s.tx;
      ty = s.ty;
      ax = 0;
      ay = 0;
      d2 = len_sq(ag_px - tx, ag_py - ty);
      if (d2 < (longint'(sh_radius_sq) << (2 * FRAC_BITS_DEF))) begin
        ag_flee = 1'b1;
        steer_toward(tx, ty, ax, ay);
        ax = -ax;
        ay = -ay;
      end else if (ag_flee) begin
        // head for the rest point on the side we are moving toward
        gx = ag_vx < 0 ? longint'(sh_left_x) : longint'(sh_right_x);
        ds = len_sq(ag_px - gx, ag_py - sh_stop_y);
        steer_toward(gx, sh_stop_y, ax, ay);
        if (ds < (longint'(STOP_RADIUS_SQ) << (2 * FRAC_BITS_DEF))) ag_flee = 1'b0;
      end else begin
        steer_toward(tx, ty, ax, ay);
      end
      if (ag_py > sh_ground_y) begin
        ag_flee = 1'b1;
        ay -= (ag_py - sh_ground_y) / GROUND_DIV;
      end
      vx = ag_vx + ax;
      vy = ag_vy + ay;
      clip(vx, vy, sh_max_speed);
      ag_vx = clamp24(vx);
      ag_vy = clamp24(vy);
      ag_px = clamp24(ag_px + ag_vx);
      ag_py = clamp24(ag_py + ag_vy);
    end
    a.pos_x = ag_px[23:0];
    a.pos_y = ag_py[23:0];
    a.vel_x = ag_vx[23:0];
    a.vel_y = ag_vy[23:0];
    a.flee  = ag_flee;
    agent_q.push_back(a);
  endtask

  // Sender: hold the beat until taken, then idle for a random gap.
  step_t cur_step;
  int    send_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(5, 1);
    return $urandom_range(200, 20);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        advance_agent(cur_step);
        steps_sent++;
        if (cur_step.mode == MODE_PLACE) places_sent++;
        step_held = 1'b0;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered beat
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (step_q.size() > 0) begin
        cur_step = step_q.pop_front();
        step_held = 1'b1;
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= cur_step.mode;
        req_ch.target_x <= cur_step.tx;
        req_ch.target_y <= cur_step.ty;
        req_ch.place_x  <= cur_step.px;
        req_ch.place_y  <= cur_step.py;
        send_gap <= pick_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
  int stall_seen = 0;
  int hold_left = 0;

  task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin
    agent_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        beats_seen++;
        if (agent_q.size() == 0) begin
          $error("result beat with no step outstanding");
          errors++;
        end else begin
          want = agent_q.pop_front();
          check_field("out_pos_x", want.pos_x, rsp_ch.out_pos_x);
          check_field("out_pos_y", want.pos_y, rsp_ch.out_pos_y);
          check_field("out_vel_x", want.vel_x, rsp_ch.out_vel_x);
          check_field("out_vel_y", want.vel_y, rsp_ch.out_vel_y);
          check_field("out_fleeing", want.flee, rsp_ch.out_fleeing);
          if (rsp_ch.out_fleeing) flee_beats++;
        end
      end
      if (stall_ask != stall_seen) begin
        stall_seen = stall_ask;
        hold_left = STALL_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (no_idle) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) < 70);
      end
    end
  end

  // Register write: setup cycle, access cycle; the shadow follows at the write edge.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_FLEE_RADIUS_SQ: sh_radius_sq = val[23:0];
      REG_GROUND_Y:       sh_ground_y  = val[23:0];
      REG_LEFT_STOP_X:    sh_left_x    = val[23:0];
      REG_RIGHT_STOP_X:   sh_right_x   = val[23:0];
      REG_STOP_Y:         sh_stop_y    = val[23:0];
      REG_MAX_SPEED:      sh_max_speed = val[15:0];
      REG_MAX_FORCE:      sh_max_force = val[15:0];
      REG_CHASE_WEIGHT:   sh_weight    = val[15:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] rad, logic [31:0] gnd, logic [31:0] lx,
                          logic [31:0] rx, logic [31:0] sy, logic [31:0] spd,
                          logic [31:0] frc, logic [31:0] wgt);
    reg_write(REG_FLEE_RADIUS_SQ, rad);
    reg_write(REG_GROUND_Y, gnd);
    reg_write(REG_LEFT_STOP_X, lx);
    reg_write(REG_RIGHT_STOP_X, rx);
    reg_write(REG_STOP_Y, sy);
    reg_write(REG_MAX_SPEED, spd);
    reg_write(REG_MAX_FORCE, frc);
    reg_write(REG_CHASE_WEIGHT, wgt);
  endtask

  task automatic drain();
    wait (step_q.size() == 0 && !step_held && agent_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_step(bit mode, int tx, int ty, int px, int py);
    step_t s;
    s.mode = mode;
    s.tx = tx[23:0];
    s.ty = ty[23:0];
    s.px = px[23:0];
    s.py = py[23:0];
    step_q.push_back(s);
  endtask

  // Mostly ticks with targets on screen, some places, some full-range noise.
  function automatic int coord();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(80000);
    if (r < 90) return $urandom_range(300000) - 20000;
    return $urandom();
  endfunction

  task automatic queue_random(int n);
    repeat (n) begin
      if ($urandom_range(99) < 10) push_step(MODE_PLACE, $urandom(), $urandom(), coord(), coord());
      else push_step(MODE_TICK, coord(), coord(), $urandom(), $urandom());
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_TICK;
    req_ch.target_x = '0;
    req_ch.target_y = '0;
    req_ch.place_x = '0;
    req_ch.place_y = '0;
    rsp_ch.ready = 1'b0;
    sh_radius_sq = FLEE_RADIUS_SQ_RST;
    sh_ground_y  = GROUND_Y_RST;
    sh_left_x    = LEFT_STOP_X_RST;
    sh_right_x   = RIGHT_STOP_X_RST;
    sh_stop_y    = STOP_Y_RST;
    sh_max_speed = MAX_SPEED_RST;
    sh_max_force = MAX_FORCE_RST;
    sh_weight    = CHASE_WEIGHT_RST;
    ag_px = 0;
    ag_py = 0;
    ag_vx = 0;
    ag_vy = 0;
    ag_flee = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed steps at reset defaults.
    push_step(MODE_TICK, 0, 0, -1, -1);                      // zero vector stays zero
    push_step(MODE_TICK, 1000, 1000, 0, 0);                  // flee near target
    push_step(MODE_TICK, 8388607, -8388608, 0, 0);           // far target: run for a stop
    push_step(MODE_PLACE, 0, 0, 235776 - 256, 19712);        // next to the right stop
    push_step(MODE_TICK, 8388607, 8388607, 0, 0);            // leave flee at the stop
    push_step(MODE_TICK, 26112, 19712 + 2560, 0, 0);
    push_step(MODE_TICK, -8388608, 8388607, 0, 0);
    push_step(MODE_PLACE, 0, 0, 26112, 19712);
    push_step(MODE_TICK, 30000, 19712, 0, 0);                // flee left; the next step seeks the left stop
    push_step(MODE_TICK, 8388607, 8388607, 0, 0);
    push_step(MODE_PLACE, 0, 0, 60000, 200000);              // below ground
    push_step(MODE_TICK, 60000, 0, 0, 0);
    push_step(MODE_TICK, 60000, 0, 0, 0);
    push_step(MODE_PLACE, 0, 0, 8388607, 8388607);
    push_step(MODE_TICK, -8388608, -8388608, 0, 0);
    push_step(MODE_PLACE, 0, 0, -8388608, -8388608);
    push_step(MODE_TICK, 8388607, 8388607, 0, 0);
    push_step(MODE_TICK, -8388608, -8388608, 0, 0);
    queue_random(RANDOM_PER_PHASE);
    drain();

    // Moderate random settings, no idling at all; then let the sender pause.
    set_regs($urandom_range(40000), $urandom_range(150000), $urandom_range(60000),
             $urandom_range(300000, 150000), $urandom_range(60000),
             $urandom_range(3000, 200), $urandom_range(600, 5), $urandom_range(512, 64));
    no_idle = 1'b1;
    queue_random(RANDOM_PER_PHASE);
    drain();
    no_idle = 1'b0;

    // Upper extremes; hold the result side off while steps keep coming.
    set_regs(32'hFFFFFF, 32'h7FFFFF, 32'h800000, 32'h7FFFFF, 32'h800000,
             32'hFFFF, 32'hFFFF, 32'hFFFF);
    stall_ask++;
    queue_random(RANDOM_PER_PHASE);
    drain();

    // Lower extremes.
    set_regs(32'h0, 32'h800000, 32'h7FFFFF, 32'h800000, 32'h7FFFFF, 32'h0, 32'h0, 32'h0);
    queue_random(RANDOM_PER_PHASE);
    drain();

    // Back near defaults with a stronger force, plus one more long hold-off.
    set_regs(14400, 117760, 26112, 235776, 19712, 768, 200, 300);
    push_step(MODE_PLACE, 0, 0, 0, 0);
    queue_random(RANDOM_PER_PHASE);
    stall_ask++;
    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d steps (%0d places), %0d result beats, %0d in flee state",
             steps_sent, places_sent, beats_seen, flee_beats);
    $display("five register settings, extremes included, with stalls on both sides");
    if (errors == 0 && agent_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout: %0d results still outstanding", agent_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
